FILE: design/psa_pkg.sv
// shared types and constants of the path segment assembler
package psa_pkg;

   localparam int COORD_WIDTH = 32;
   localparam int QUEUE_DEPTH = 3;
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int QUEUE_IDX_W = $clog2(QUEUE_DEPTH);

   localparam logic [1:0] KIND_ON_CURVE = 2'd0;
   localparam logic [1:0] KIND_CTRL_A   = 2'd1;
   localparam logic [1:0] KIND_CTRL_B   = 2'd2;

   localparam logic [1:0] SEG_LINE  = 2'd0;
   localparam logic [1:0] SEG_QUAD  = 2'd1;
   localparam logic [1:0] SEG_CUBIC = 2'd2;

   localparam logic [1:0] STAGE_IDLE   = 2'd0;
   localparam logic [1:0] STAGE_START  = 2'd1;
   localparam logic [1:0] STAGE_CTRL_A = 2'd2;
   localparam logic [1:0] STAGE_CTRL_B = 2'd3;

   localparam logic [1:0] TALLY_MAX = 2'd2;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] coord_x;
      logic signed [COORD_WIDTH-1:0] coord_y;
      logic [1:0]                    point_kind;
      logic                          path_closed;
      logic                          end_of_path;
   } req_type;

   typedef struct packed {
      logic [1:0]                    seg_kind;
      logic signed [COORD_WIDTH-1:0] from_x;
      logic signed [COORD_WIDTH-1:0] from_y;
      logic signed [COORD_WIDTH-1:0] ctrl_a_x;
      logic signed [COORD_WIDTH-1:0] ctrl_a_y;
      logic signed [COORD_WIDTH-1:0] ctrl_b_x;
      logic signed [COORD_WIDTH-1:0] ctrl_b_y;
      logic signed [COORD_WIDTH-1:0] to_x;
      logic signed [COORD_WIDTH-1:0] to_y;
      logic                          closing_line;
      logic                          last_result;
   } rsp_type;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] start_x;
      logic signed [COORD_WIDTH-1:0] start_y;
      logic signed [COORD_WIDTH-1:0] pend_a_x;
      logic signed [COORD_WIDTH-1:0] pend_a_y;
      logic signed [COORD_WIDTH-1:0] pend_b_x;
      logic signed [COORD_WIDTH-1:0] pend_b_y;
      logic signed [COORD_WIDTH-1:0] first_x;
      logic signed [COORD_WIDTH-1:0] first_y;
      logic [1:0]                    segment_stage;
      logic [1:0]                    point_tally;
      logic                          path_stopped;
   } state_type;

   // results produced by one request, in delivery order
   typedef struct packed {
      logic [1:0] num;
      rsp_type    res_a;
      rsp_type    res_b;
   } build_type;

endpackage

FILE: design/psa_seg_unit.sv
// segment building logic: next path state and results for one request
module psa_seg_unit (
   input  psa_pkg::state_type state_cur,
   input  psa_pkg::req_type   req,
   input  logic               force_close,
   output psa_pkg::state_type state_nxt,
   output psa_pkg::build_type build
);

   psa_pkg::state_type nxt;
   psa_pkg::rsp_type   seg;
   psa_pkg::rsp_type   close_res;
   logic               seg_hit;
   logic               close_hit;

   always_comb begin
      nxt     = state_cur;
      seg_hit = 1'b0;
      seg     = '0;
      if (!state_cur.path_stopped) begin
         if (state_cur.point_tally < psa_pkg::TALLY_MAX) begin
            nxt.point_tally = state_cur.point_tally + 2'd1;
         end
         seg.from_x = state_cur.start_x;
         seg.from_y = state_cur.start_y;
         seg.to_x   = req.coord_x;
         seg.to_y   = req.coord_y;
         case (state_cur.segment_stage)
            psa_pkg::STAGE_IDLE: begin
               if (req.point_kind == psa_pkg::KIND_ON_CURVE) begin
                  nxt.first_x       = req.coord_x;
                  nxt.first_y       = req.coord_y;
                  nxt.start_x       = req.coord_x;
                  nxt.start_y       = req.coord_y;
                  nxt.segment_stage = psa_pkg::STAGE_START;
               end else begin
                  nxt.path_stopped = 1'b1;
               end
            end
            psa_pkg::STAGE_START: begin
               if (req.point_kind == psa_pkg::KIND_ON_CURVE) begin
                  seg_hit      = 1'b1;
                  seg.seg_kind = psa_pkg::SEG_LINE;
                  nxt.start_x  = req.coord_x;
                  nxt.start_y  = req.coord_y;
               end else if (req.point_kind == psa_pkg::KIND_CTRL_A) begin
                  nxt.pend_a_x      = req.coord_x;
                  nxt.pend_a_y      = req.coord_y;
                  nxt.segment_stage = psa_pkg::STAGE_CTRL_A;
               end else begin
                  nxt.path_stopped = 1'b1;
               end
            end
            psa_pkg::STAGE_CTRL_A: begin
               if (req.point_kind == psa_pkg::KIND_ON_CURVE) begin
                  seg_hit           = 1'b1;
                  seg.seg_kind      = psa_pkg::SEG_QUAD;
                  seg.ctrl_a_x      = state_cur.pend_a_x;
                  seg.ctrl_a_y      = state_cur.pend_a_y;
                  nxt.start_x       = req.coord_x;
                  nxt.start_y       = req.coord_y;
                  nxt.segment_stage = psa_pkg::STAGE_START;
               end else if (req.point_kind == psa_pkg::KIND_CTRL_B) begin
                  nxt.pend_b_x      = req.coord_x;
                  nxt.pend_b_y      = req.coord_y;
                  nxt.segment_stage = psa_pkg::STAGE_CTRL_B;
               end else begin
                  nxt.path_stopped = 1'b1;
               end
            end
            default: begin
               if (req.point_kind == psa_pkg::KIND_ON_CURVE) begin
                  seg_hit           = 1'b1;
                  seg.seg_kind      = psa_pkg::SEG_CUBIC;
                  seg.ctrl_a_x      = state_cur.pend_a_x;
                  seg.ctrl_a_y      = state_cur.pend_a_y;
                  seg.ctrl_b_x      = state_cur.pend_b_x;
                  seg.ctrl_b_y      = state_cur.pend_b_y;
                  nxt.start_x       = req.coord_x;
                  nxt.start_y       = req.coord_y;
                  nxt.segment_stage = psa_pkg::STAGE_START;
               end else begin
                  nxt.path_stopped = 1'b1;
               end
            end
         endcase
      end

      // closing line looks at the state after this point is taken in
      close_res              = '0;
      close_res.seg_kind     = psa_pkg::SEG_LINE;
      close_res.from_x       = nxt.start_x;
      close_res.from_y       = nxt.start_y;
      close_res.to_x         = nxt.first_x;
      close_res.to_y         = nxt.first_y;
      close_res.closing_line = 1'b1;
      close_res.last_result  = 1'b1;
      close_hit = req.end_of_path && !nxt.path_stopped &&
                  (nxt.segment_stage == psa_pkg::STAGE_START) &&
                  (nxt.point_tally == psa_pkg::TALLY_MAX) &&
                  (req.path_closed || force_close);

      seg.last_result = !close_hit;

      build = '0;
      if (seg_hit) begin
         build.res_a = seg;
         build.res_b = close_res;
         build.num   = close_hit ? 2'd2 : 2'd1;
      end else begin
         build.res_a = close_res;
         build.num   = close_hit ? 2'd1 : 2'd0;
      end

      state_nxt = req.end_of_path ? psa_pkg::state_type'('0) : nxt;
   end

endmodule

FILE: design/psa_rsp_queue.sv
// small result queue: takes up to two results a cycle, delivers one
module psa_rsp_queue (
   input  logic                           clock,
   input  logic                           reset,
   input  psa_pkg::build_type             push,
   input  logic                           pop,
   output logic                           head_valid,
   output psa_pkg::rsp_type               head,
   output logic [psa_pkg::QUEUE_CNT_W-1:0] fill
);

   psa_pkg::rsp_type                entry_ff [psa_pkg::QUEUE_DEPTH];
   psa_pkg::rsp_type                entry_in [psa_pkg::QUEUE_DEPTH];
   logic [psa_pkg::QUEUE_CNT_W-1:0] count_ff;
   logic [psa_pkg::QUEUE_CNT_W-1:0] count_in;
   logic [psa_pkg::QUEUE_CNT_W-1:0] base;
   logic [psa_pkg::QUEUE_CNT_W-1:0] base_b;

   always_comb begin
      base     = count_ff - psa_pkg::QUEUE_CNT_W'(pop);
      base_b   = base + psa_pkg::QUEUE_CNT_W'(1);
      count_in = base + psa_pkg::QUEUE_CNT_W'(push.num);
      for (int i = 0; i < psa_pkg::QUEUE_DEPTH; i++) begin
         // shift towards the head on a pop
         if (pop && (i < psa_pkg::QUEUE_DEPTH - 1)) begin
            entry_in[i] = entry_ff[(i + 1) % psa_pkg::QUEUE_DEPTH];
         end else begin
            entry_in[i] = entry_ff[i];
         end
         if ((push.num != 2'd0) && (base == psa_pkg::QUEUE_CNT_W'(i))) begin
            entry_in[i] = push.res_a;
         end
         if ((push.num == 2'd2) && (base_b == psa_pkg::QUEUE_CNT_W'(i))) begin
            entry_in[i] = push.res_b;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < psa_pkg::QUEUE_DEPTH; i++) begin
         entry_ff[i] <= entry_in[i];
      end
   end

   assign head_valid = (count_ff != '0);
   assign head       = entry_ff[psa_pkg::QUEUE_IDX_W'(0)];
   assign fill       = count_ff;

endmodule

FILE: design/path_segment_assembler_core.sv
// Path segment assembler: groups a stream of tagged path points into line,
// quadratic and cubic segments, with an optional closing line per path.
// One point is accepted per clock cycle while req_stall is low. Segment
// building is a single registered pass from the point and the held path
// state into a three-entry result queue; a point that finishes a segment
// and also closes the path places two results there, and req_stall rises
// while the queue holds two or more results. With rsp_stall low and at
// most one result per point, points flow every cycle and rsp_valid rises in
// the cycle after acceptance. The user writes force_close through csr_wr_en
// and csr_wr_data while the block is idle; the block does not enforce it.
module path_segment_assembler_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  psa_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output psa_pkg::rsp_type rsp_data,
   input  logic             csr_wr_en,
   input  logic             csr_wr_data
);

   psa_pkg::state_type              state_ff;
   psa_pkg::state_type              state_in;
   psa_pkg::state_type              state_calc;
   psa_pkg::build_type              build;
   psa_pkg::build_type              push;
   logic                            force_close_ff;
   logic                            req_accept;
   logic                            rsp_pop;
   logic [psa_pkg::QUEUE_CNT_W-1:0] fill;

   psa_seg_unit u_seg (
      .state_cur   (state_ff),
      .req         (req_data),
      .force_close (force_close_ff),
      .state_nxt   (state_calc),
      .build       (build)
   );

   // room for two new results is kept whenever a request may be taken
   assign req_stall  = (fill > psa_pkg::QUEUE_CNT_W'(1));
   assign req_accept = req_valid && !req_stall;
   assign rsp_pop    = rsp_valid && !rsp_stall;

   always_comb begin
      push     = build;
      state_in = state_ff;
      if (req_accept) begin
         state_in = state_calc;
      end else begin
         push.num = 2'd0;
      end
   end

   psa_rsp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .pop        (rsp_pop),
      .head_valid (rsp_valid),
      .head       (rsp_data),
      .fill       (fill)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= '0;
         force_close_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            force_close_ff <= csr_wr_data;
         end
      end
   end

`ifndef ASSERT_OFF
   a_stall_needs_results: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("request stalled with no result queued");

   a_path_end_clears: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_data.end_of_path |=>
         (state_ff.segment_stage == psa_pkg::STAGE_IDLE) &&
         !state_ff.path_stopped && (state_ff.point_tally == 2'd0))
      else $error("path state not cleared after end of path");

   a_tally_saturates: assert property (@(posedge clock) disable iff (reset)
      state_ff.point_tally <= psa_pkg::TALLY_MAX)
      else $error("point tally above saturation");

   a_no_work_when_stopped: assert property (@(posedge clock) disable iff (reset)
      req_accept && state_ff.path_stopped && !req_data.end_of_path |=>
         state_ff.path_stopped && $stable(state_ff.segment_stage))
      else $error("stopped path changed state");
`endif

endmodule
